@@ src/assert_macros.svh @@
// Assertion macros shared by the interpolator RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define HI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define HI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/hi_pkg.sv @@
// Package for the Hermite interpolator: widths, fixed-point constants, register codes.
// Used by the channel interfaces, hi_coef and hermite_interpolator; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package hi_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int FRACTION_WIDTH = 16;
    localparam int COEF_BITS      = 14;
    localparam int WEIGHT_BITS    = 24;
    localparam int TANGENT_BITS   = ((35 - SAMPLE_WIDTH) < COEF_BITS) ?
                                    (35 - SAMPLE_WIDTH) : COEF_BITS;
    localparam int TAN_SHIFT      = COEF_BITS - TANGENT_BITS;

    // Configuration port
    localparam int CFG_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH = 8;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_TENSION = CFG_INDEX_WIDTH'(0),
        REG_BIAS    = CFG_INDEX_WIDTH'(1)
    } cfg_reg_t;

    // Tangent factors
    localparam int FACT_W      = COEF_BITS + 4;
    localparam int FACT_PROD_W = 2 * FACT_W;
    localparam logic signed [FACT_W-1:0] COEF_ONE = FACT_W'(1 << COEF_BITS);
    localparam logic signed [FACT_W-1:0] FACT_RESET =
        FACT_W'((1 << (2 * COEF_BITS)) >> (COEF_BITS + 1));
    localparam logic signed [FACT_PROD_W-1:0] FACT_RND = FACT_PROD_W'(1) << COEF_BITS;

    // Data path widths
    localparam int DIFF_W  = SAMPLE_WIDTH + 1;
    localparam int TPROD_W = DIFF_W + FACT_W;
    localparam int TAN_W   = TPROD_W + 1;
    localparam int WU_W    = WEIGHT_BITS + 1;
    localparam int SQ_W    = 2 * WEIGHT_BITS;
    localparam int CUBE_W  = WU_W + WEIGHT_BITS;
    localparam int H_W     = WEIGHT_BITS + 4;
    localparam int LO_W    = 18;
    localparam int HI_W    = TAN_W - LO_W;
    localparam int HD_W    = H_W + DIFF_W;
    localparam int HLO_W   = H_W + LO_W + 1;
    localparam int HHI_W   = H_W + HI_W;
    localparam int OUT_SHIFT = WEIGHT_BITS + TANGENT_BITS;
    localparam int SUM_W   = SAMPLE_WIDTH + OUT_SHIFT + 6;
    localparam int V_W     = SUM_W - OUT_SHIFT;

    localparam logic [SQ_W:0]   SQ_RND   = (SQ_W + 1)'(1) << (WEIGHT_BITS - 1);
    localparam logic [CUBE_W:0] CUBE_RND = (CUBE_W + 1)'(1) << (WEIGHT_BITS - 1);
    localparam logic signed [TAN_W-1:0] TAN_RND = (TAN_W'(1) << TAN_SHIFT) >> 1;
    localparam logic signed [SUM_W-1:0] OUT_RND = SUM_W'(1) << (OUT_SHIFT - 1);

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX =
        {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN =
        {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

    localparam int NUM_STAGES = 7;

    typedef struct packed {
        logic signed [FACT_W-1:0] fp;
        logic signed [FACT_W-1:0] fq;
    } coef_t;

endpackage

`default_nettype wire

@@ src/hi_in_if.sv @@
// Input channel of the interpolator: four samples and a fraction per transaction.
// Depends on hi_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface hi_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [hi_pkg::SAMPLE_WIDTH-1:0] sample_before;
    logic signed [hi_pkg::SAMPLE_WIDTH-1:0] sample_start;
    logic signed [hi_pkg::SAMPLE_WIDTH-1:0] sample_end;
    logic signed [hi_pkg::SAMPLE_WIDTH-1:0] sample_after;
    logic        [hi_pkg::FRACTION_WIDTH-1:0] fraction;

    modport source (
        output valid, sample_before, sample_start, sample_end, sample_after, fraction,
        input  ready
    );
    modport sink (
        input  valid, sample_before, sample_start, sample_end, sample_after, fraction,
        output ready
    );
endinterface

`default_nettype wire

@@ src/hi_out_if.sv @@
// Result channel of the interpolator: interpolated sample and saturation flag.
// Depends on hi_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface hi_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [hi_pkg::SAMPLE_WIDTH-1:0] value;
    logic                                   saturated;

    modport source (output valid, value, saturated, input ready);
    modport sink   (input valid, value, saturated, output ready);
endinterface

`default_nettype wire

@@ src/hi_cfg_if.sv @@
// Configuration write channel: register index and write data per transaction.
// Depends on hi_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface hi_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [hi_pkg::CFG_INDEX_WIDTH-1:0]   index;
    logic signed [hi_pkg::CFG_WIDTH-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/hi_coef.sv @@
// Tension and bias registers plus the two tangent factors derived from them.
// Depends on hi_pkg, hi_cfg_if and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hi_coef (
    input  wire logic      clk,
    input  wire logic      rst_n,
    hi_cfg_if.sink         cfg,
    output hi_pkg::coef_t  coef
);

    logic signed [hi_pkg::CFG_WIDTH-1:0]   tension_reg, tension_next;
    logic signed [hi_pkg::CFG_WIDTH-1:0]   bias_reg, bias_next;
    hi_pkg::coef_t                         coef_reg, coef_next;
    logic                                  wr_tension, wr_bias;
    logic signed [hi_pkg::FACT_W-1:0]      plus_b, minus_b, minus_t;
    logic signed [hi_pkg::FACT_PROD_W-1:0] prod_p, prod_q;

    assign cfg.ready = 1'b1;

    assign wr_tension = cfg.valid && (cfg.index == hi_pkg::REG_TENSION);
    assign wr_bias    = cfg.valid && (cfg.index == hi_pkg::REG_BIAS);

    // The factors are recomputed from the value being written, so they are
    // current at the same edge as the register itself.
    always_comb
    begin
        tension_next = wr_tension ? cfg.data : tension_reg;
        bias_next    = wr_bias ? cfg.data : bias_reg;
        plus_b  = hi_pkg::COEF_ONE + hi_pkg::FACT_W'(bias_next);
        minus_b = hi_pkg::COEF_ONE - hi_pkg::FACT_W'(bias_next);
        minus_t = hi_pkg::COEF_ONE - hi_pkg::FACT_W'(tension_next);
        prod_p  = hi_pkg::FACT_PROD_W'(plus_b) * hi_pkg::FACT_PROD_W'(minus_t);
        prod_q  = hi_pkg::FACT_PROD_W'(minus_b) * hi_pkg::FACT_PROD_W'(minus_t);
        coef_next.fp = hi_pkg::FACT_W'((prod_p + hi_pkg::FACT_RND) >>> (hi_pkg::COEF_BITS + 1));
        coef_next.fq = hi_pkg::FACT_W'((prod_q + hi_pkg::FACT_RND) >>> (hi_pkg::COEF_BITS + 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tension_reg <= '0;
            bias_reg    <= '0;
            coef_reg.fp <= hi_pkg::FACT_RESET;
            coef_reg.fq <= hi_pkg::FACT_RESET;
        end
        else if (wr_tension || wr_bias)
        begin
            tension_reg <= tension_next;
            bias_reg    <= bias_next;
            coef_reg    <= coef_next;
        end
    end

    assign coef = coef_reg;

    `HI_ASSERT_NXT(a_unknown_index_ignored,
        cfg.valid && cfg.ready && cfg.index != hi_pkg::REG_TENSION &&
        cfg.index != hi_pkg::REG_BIAS,
        $stable(coef_reg) && $stable(tension_reg) && $stable(bias_reg),
        "write to an unknown register index changed the coefficients")
    `HI_ASSERT_IMP(a_unit_tension_flat,
        tension_reg == hi_pkg::COEF_ONE,
        coef_reg.fp == '0 && coef_reg.fq == '0,
        "unit tension must give zero tangent factors")

endmodule

`default_nettype wire

@@ src/hermite_interpolator.sv @@
// Top level of the cubic Hermite interpolator with tension and bias.
// Depends on hi_pkg, the channel interfaces, hi_coef and assert_macros.svh.
//
//  Channel  Port    Role    Transaction
//  -------  ------  ------  ----------------------------------------------
//  input    item    sink    four samples and a Q0.16 fraction
//  result   result  source  rounded, saturated sample and clip flag
//  config   cfg     sink    register index and 16-bit data, always ready
//
// Seven register stages; one item per clock while the result is not stalled. An
// accepted input enters stage 0 and its result is offered from stage 6. The stage
// count is set by the square and cube chain for the basis weights and the split
// tangent products. Reset clears the stage valid bits and sets tension and bias to zero.
// A stalled result holds only the stages behind it that are full; empty
// stages keep filling, so input ready drops only when all seven are full.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hermite_interpolator (
    input  wire logic clk,
    input  wire logic rst_n,
    hi_in_if.sink     item,
    hi_out_if.source  result,
    hi_cfg_if.sink    cfg
);

    localparam int NS = hi_pkg::NUM_STAGES;

    hi_pkg::coef_t coef;

    hi_coef u_coef (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .coef  (coef)
    );

    // Stage control
    logic [NS-1:0] vld_reg, vld_next;
    logic [NS-1:0] take;
    logic [NS-1:0] ld;

    always_comb
    begin
        take[NS-1] = !vld_reg[NS-1] || result.ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            take[k] = !vld_reg[k] || take[k+1];
        end
        ld[0]       = take[0] && item.valid;
        vld_next[0] = take[0] ? item.valid : vld_reg[0];
        for (int k = 1; k < NS; k++)
        begin
            ld[k]       = take[k] && vld_reg[k-1];
            vld_next[k] = take[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage 0: differences, widened fraction, fraction squared
    logic signed [hi_pkg::SAMPLE_WIDTH-1:0] s0_y1_reg;
    logic signed [hi_pkg::DIFF_W-1:0]       s0_d10_reg, s0_d21_reg, s0_d32_reg;
    logic signed [hi_pkg::DIFF_W-1:0]       s0_d10_next, s0_d21_next, s0_d32_next;
    logic [hi_pkg::WEIGHT_BITS-1:0]         s0_u_reg, s0_u_next;
    logic [hi_pkg::SQ_W-1:0]                s0_sq_reg, s0_sq_next;

    // Stage 1: rounded square, four tangent products
    logic signed [hi_pkg::SAMPLE_WIDTH-1:0] s1_y1_reg;
    logic signed [hi_pkg::DIFF_W-1:0]       s1_d21_reg;
    logic [hi_pkg::WEIGHT_BITS-1:0]         s1_u_reg;
    logic [hi_pkg::WU_W-1:0]                s1_u2_reg, s1_u2_next;
    logic signed [hi_pkg::TPROD_W-1:0]      s1_pa_reg, s1_pb_reg, s1_pc_reg, s1_pd_reg;
    logic signed [hi_pkg::TPROD_W-1:0]      s1_pa_next, s1_pb_next, s1_pc_next, s1_pd_next;

    // Stage 2: cube product, tangents
    logic signed [hi_pkg::SAMPLE_WIDTH-1:0] s2_y1_reg;
    logic signed [hi_pkg::DIFF_W-1:0]       s2_d21_reg;
    logic [hi_pkg::WEIGHT_BITS-1:0]         s2_u_reg;
    logic [hi_pkg::WU_W-1:0]                s2_u2_reg;
    logic [hi_pkg::CUBE_W-1:0]              s2_cube_reg, s2_cube_next;
    logic signed [hi_pkg::TAN_W-1:0]        s2_m0_reg, s2_m1_reg, s2_m0_next, s2_m1_next;

    // Stage 3: basis weights
    logic signed [hi_pkg::SAMPLE_WIDTH-1:0] s3_y1_reg;
    logic signed [hi_pkg::DIFF_W-1:0]       s3_d21_reg;
    logic signed [hi_pkg::TAN_W-1:0]        s3_m0_reg, s3_m1_reg;
    logic signed [hi_pkg::H_W-1:0]          s3_h1_reg, s3_h2_reg, s3_h3_reg;
    logic signed [hi_pkg::H_W-1:0]          s3_h1_next, s3_h2_next, s3_h3_next;
    logic [hi_pkg::WU_W-1:0]                u3;
    logic signed [hi_pkg::H_W-1:0]          u_s, u2_s, u3_s;

    // Stage 4: weighted products, tangents split into low and high halves
    logic signed [hi_pkg::SAMPLE_WIDTH-1:0] s4_y1_reg;
    logic signed [hi_pkg::HD_W-1:0]         s4_hd_reg, s4_hd_next;
    logic signed [hi_pkg::HLO_W-1:0]        s4_h1lo_reg, s4_h2lo_reg, s4_h1lo_next, s4_h2lo_next;
    logic signed [hi_pkg::HHI_W-1:0]        s4_h1hi_reg, s4_h2hi_reg, s4_h1hi_next, s4_h2hi_next;
    logic signed [hi_pkg::LO_W:0]           m0_lo, m1_lo;
    logic signed [hi_pkg::HI_W-1:0]         m0_hi, m1_hi;

    // Stage 5: partial sums
    logic signed [hi_pkg::SUM_W-1:0]        s5_base_reg, s5_pm0_reg, s5_pm1_reg;
    logic signed [hi_pkg::SUM_W-1:0]        s5_base_next, s5_pm0_next, s5_pm1_next;

    // Stage 6: final sum, rounding, saturation
    logic signed [hi_pkg::SAMPLE_WIDTH-1:0] s6_value_reg, s6_value_next;
    logic                                   s6_sat_reg, s6_sat_next;
    logic signed [hi_pkg::SUM_W-1:0]        sum;
    logic signed [hi_pkg::V_W-1:0]          v;

    always_comb
    begin
        // Stage 0
        s0_d10_next = hi_pkg::DIFF_W'(item.sample_start) - hi_pkg::DIFF_W'(item.sample_before);
        s0_d21_next = hi_pkg::DIFF_W'(item.sample_end) - hi_pkg::DIFF_W'(item.sample_start);
        s0_d32_next = hi_pkg::DIFF_W'(item.sample_after) - hi_pkg::DIFF_W'(item.sample_end);
        s0_u_next   = hi_pkg::WEIGHT_BITS'(item.fraction)
                      << (hi_pkg::WEIGHT_BITS - hi_pkg::FRACTION_WIDTH);
        s0_sq_next  = hi_pkg::SQ_W'(s0_u_next) * hi_pkg::SQ_W'(s0_u_next);

        // Stage 1
        s1_u2_next = hi_pkg::WU_W'(((hi_pkg::SQ_W + 1)'(s0_sq_reg) + hi_pkg::SQ_RND)
                                   >> hi_pkg::WEIGHT_BITS);
        s1_pa_next = hi_pkg::TPROD_W'(s0_d10_reg) * hi_pkg::TPROD_W'(coef.fp);
        s1_pb_next = hi_pkg::TPROD_W'(s0_d21_reg) * hi_pkg::TPROD_W'(coef.fq);
        s1_pc_next = hi_pkg::TPROD_W'(s0_d21_reg) * hi_pkg::TPROD_W'(coef.fp);
        s1_pd_next = hi_pkg::TPROD_W'(s0_d32_reg) * hi_pkg::TPROD_W'(coef.fq);

        // Stage 2
        s2_cube_next = hi_pkg::CUBE_W'(s1_u2_reg) * hi_pkg::CUBE_W'(s1_u_reg);
        s2_m0_next = (hi_pkg::TAN_W'(s1_pa_reg) + hi_pkg::TAN_W'(s1_pb_reg) + hi_pkg::TAN_RND)
                     >>> hi_pkg::TAN_SHIFT;
        s2_m1_next = (hi_pkg::TAN_W'(s1_pc_reg) + hi_pkg::TAN_W'(s1_pd_reg) + hi_pkg::TAN_RND)
                     >>> hi_pkg::TAN_SHIFT;

        // Stage 3: h1 = u3 - 2u2 + u, h2 = u3 - u2, h3 = 3u2 - 2u3
        u3   = hi_pkg::WU_W'(((hi_pkg::CUBE_W + 1)'(s2_cube_reg) + hi_pkg::CUBE_RND)
                             >> hi_pkg::WEIGHT_BITS);
        u_s  = $signed(hi_pkg::H_W'(s2_u_reg));
        u2_s = $signed(hi_pkg::H_W'(s2_u2_reg));
        u3_s = $signed(hi_pkg::H_W'(u3));
        s3_h1_next = u3_s - (u2_s <<< 1) + u_s;
        s3_h2_next = u3_s - u2_s;
        s3_h3_next = (u2_s <<< 1) + u2_s - (u3_s <<< 1);

        // Stage 4
        m0_lo = $signed({1'b0, s3_m0_reg[hi_pkg::LO_W-1:0]});
        m1_lo = $signed({1'b0, s3_m1_reg[hi_pkg::LO_W-1:0]});
        m0_hi = $signed(s3_m0_reg[hi_pkg::TAN_W-1:hi_pkg::LO_W]);
        m1_hi = $signed(s3_m1_reg[hi_pkg::TAN_W-1:hi_pkg::LO_W]);
        s4_hd_next   = hi_pkg::HD_W'(s3_h3_reg) * hi_pkg::HD_W'(s3_d21_reg);
        s4_h1lo_next = hi_pkg::HLO_W'(s3_h1_reg) * hi_pkg::HLO_W'(m0_lo);
        s4_h2lo_next = hi_pkg::HLO_W'(s3_h2_reg) * hi_pkg::HLO_W'(m1_lo);
        s4_h1hi_next = hi_pkg::HHI_W'(s3_h1_reg) * hi_pkg::HHI_W'(m0_hi);
        s4_h2hi_next = hi_pkg::HHI_W'(s3_h2_reg) * hi_pkg::HHI_W'(m1_hi);

        // Stage 5: the rounding offset rides along in the base term.
        s5_pm0_next  = (hi_pkg::SUM_W'(s4_h1hi_reg) <<< hi_pkg::LO_W)
                       + hi_pkg::SUM_W'(s4_h1lo_reg);
        s5_pm1_next  = (hi_pkg::SUM_W'(s4_h2hi_reg) <<< hi_pkg::LO_W)
                       + hi_pkg::SUM_W'(s4_h2lo_reg);
        s5_base_next = (hi_pkg::SUM_W'(s4_y1_reg) <<< hi_pkg::OUT_SHIFT)
                       + (hi_pkg::SUM_W'(s4_hd_reg) <<< hi_pkg::TANGENT_BITS)
                       + hi_pkg::OUT_RND;

        // Stage 6
        sum = s5_base_reg + s5_pm0_reg + s5_pm1_reg;
        v   = hi_pkg::V_W'(sum >>> hi_pkg::OUT_SHIFT);
        priority if (v > hi_pkg::V_W'(hi_pkg::SAMPLE_MAX))
        begin
            s6_value_next = hi_pkg::SAMPLE_MAX;
            s6_sat_next   = 1'b1;
        end
        else if (v < hi_pkg::V_W'(hi_pkg::SAMPLE_MIN))
        begin
            s6_value_next = hi_pkg::SAMPLE_MIN;
            s6_sat_next   = 1'b1;
        end
        else
        begin
            s6_value_next = hi_pkg::SAMPLE_WIDTH'(v);
            s6_sat_next   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            s0_y1_reg  <= item.sample_start;
            s0_d10_reg <= s0_d10_next;
            s0_d21_reg <= s0_d21_next;
            s0_d32_reg <= s0_d32_next;
            s0_u_reg   <= s0_u_next;
            s0_sq_reg  <= s0_sq_next;
        end
        if (ld[1])
        begin
            s1_y1_reg  <= s0_y1_reg;
            s1_d21_reg <= s0_d21_reg;
            s1_u_reg   <= s0_u_reg;
            s1_u2_reg  <= s1_u2_next;
            s1_pa_reg  <= s1_pa_next;
            s1_pb_reg  <= s1_pb_next;
            s1_pc_reg  <= s1_pc_next;
            s1_pd_reg  <= s1_pd_next;
        end
        if (ld[2])
        begin
            s2_y1_reg   <= s1_y1_reg;
            s2_d21_reg  <= s1_d21_reg;
            s2_u_reg    <= s1_u_reg;
            s2_u2_reg   <= s1_u2_reg;
            s2_cube_reg <= s2_cube_next;
            s2_m0_reg   <= s2_m0_next;
            s2_m1_reg   <= s2_m1_next;
        end
        if (ld[3])
        begin
            s3_y1_reg  <= s2_y1_reg;
            s3_d21_reg <= s2_d21_reg;
            s3_m0_reg  <= s2_m0_reg;
            s3_m1_reg  <= s2_m1_reg;
            s3_h1_reg  <= s3_h1_next;
            s3_h2_reg  <= s3_h2_next;
            s3_h3_reg  <= s3_h3_next;
        end
        if (ld[4])
        begin
            s4_y1_reg   <= s3_y1_reg;
            s4_hd_reg   <= s4_hd_next;
            s4_h1lo_reg <= s4_h1lo_next;
            s4_h2lo_reg <= s4_h2lo_next;
            s4_h1hi_reg <= s4_h1hi_next;
            s4_h2hi_reg <= s4_h2hi_next;
        end
        if (ld[5])
        begin
            s5_base_reg <= s5_base_next;
            s5_pm0_reg  <= s5_pm0_next;
            s5_pm1_reg  <= s5_pm1_next;
        end
        if (ld[6])
        begin
            s6_value_reg <= s6_value_next;
            s6_sat_reg   <= s6_sat_next;
        end
    end

    assign item.ready       = take[0];
    assign result.valid     = vld_reg[NS-1];
    assign result.value     = s6_value_reg;
    assign result.saturated = s6_sat_reg;

    `HI_ASSERT_IMP(a_empty_output_takes_input,
        !result.valid,
        item.ready,
        "input stalled although the output stage is empty")
    `HI_ASSERT_NXT(a_accept_fills_first_stage,
        item.valid && item.ready,
        vld_reg[0],
        "accepted transaction did not reach the first stage")
    `HI_ASSERT_IMP(a_saturated_at_rail,
        result.valid && result.saturated,
        result.value == hi_pkg::SAMPLE_MAX || result.value == hi_pkg::SAMPLE_MIN,
        "saturated result is not at a range limit")

endmodule

`default_nettype wire
